>>> rtl/keyboard_event_fifo_macros.svh
// assertion helpers for the rtl
`ifndef KEYBOARD_EVENT_FIFO_MACROS_SVH
`define KEYBOARD_EVENT_FIFO_MACROS_SVH

// same-cycle implication
`define KEF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyboard_event_fifo check failed");

// next-cycle implication
`define KEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyboard_event_fifo check failed");

`endif

>>> rtl/kef_pkg.sv
`default_nettype none

package kef_pkg;

   localparam int unsigned KEY_W = 8;
   localparam int unsigned REQ_W = 4;

   localparam logic [REQ_W-1:0] REQ_PRESS       = 4'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE     = 4'd1;
   localparam logic [REQ_W-1:0] REQ_CHAR_PUSH   = 4'd2;
   localparam logic [REQ_W-1:0] REQ_READ_KEY    = 4'd3;
   localparam logic [REQ_W-1:0] REQ_READ_CHAR   = 4'd4;
   localparam logic [REQ_W-1:0] REQ_QUERY_KEY   = 4'd5;
   localparam logic [REQ_W-1:0] REQ_FLUSH_KEYS  = 4'd6;
   localparam logic [REQ_W-1:0] REQ_FLUSH_CHARS = 4'd7;
   localparam logic [REQ_W-1:0] REQ_FLUSH_BOTH  = 4'd8;
   localparam logic [REQ_W-1:0] REQ_CLEAR_MAP   = 4'd9;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

>>> rtl/keyboard_event_fifo.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_type, req_key_code, req_char_code
// rsp       out        rsp_valid / rsp_stall  rsp_event_valid .. rsp_autorepeat_on
// csr       in         csr_wr_en              csr_wr_data (autorepeat enable)
//
// a request is taken in the transfer cycle, which issues the memory reads; the
// execute state sees the registered read data, writes back and loads the result
// register once no stalled result is held; memory reads are registered.
// reset is synchronous; it empties both queues and marks every key map entry
// invalid (reads as released) at once, so no clearing pass is needed.
// a stalled result holds the request in the execute state; the next transfer is
// taken once the result register has been loaded.
`default_nettype none

`include "keyboard_event_fifo_macros.svh"

module keyboard_event_fifo
   import kef_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned KEY_COUNT   = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [KEY_W-1:0]  req_key_code,
   input  wire logic [KEY_W-1:0]  req_char_code,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_event_valid,
   output      logic              rsp_event_is_press,
   output      logic [KEY_W-1:0]  rsp_event_key,
   output      logic [KEY_W-1:0]  rsp_char_out,
   output      logic              rsp_key_down,
   output      logic              rsp_key_queue_empty,
   output      logic              rsp_char_queue_empty,
   output      logic              rsp_autorepeat_on,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam int unsigned MAP_W = $clog2(KEY_COUNT);
   localparam int unsigned EV_W  = KEY_W + 1;

   // storage
   logic [EV_W-1:0]  event_mem [QUEUE_DEPTH];
   logic [KEY_W-1:0] char_mem  [QUEUE_DEPTH];
   logic             map_mem   [KEY_COUNT];
   logic [KEY_COUNT-1:0] map_valid_ff;

   state_type state_ff, state_in;

   logic [REQ_W-1:0] req_type_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] char_ff;

   logic [EV_W-1:0]  ev_rd_ff;
   logic [KEY_W-1:0] ch_rd_ff;
   logic             map_rd_ff;
   logic             map_vld_rd_ff;

   logic [PTR_W-1:0] event_head_ff, event_head_in;
   logic [CNT_W-1:0] event_count_ff, event_count_in;
   logic [PTR_W-1:0] char_head_ff, char_head_in;
   logic [CNT_W-1:0] char_count_ff, char_count_in;
   logic             autorepeat_ff, autorepeat_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_event_valid_ff, rsp_event_valid_in;
   logic             rsp_event_is_press_ff, rsp_event_is_press_in;
   logic [KEY_W-1:0] rsp_event_key_ff, rsp_event_key_in;
   logic [KEY_W-1:0] rsp_char_out_ff, rsp_char_out_in;
   logic             rsp_key_down_ff, rsp_key_down_in;
   logic             rsp_key_empty_ff, rsp_key_empty_in;
   logic             rsp_char_empty_ff, rsp_char_empty_in;
   logic             rsp_autorepeat_ff, rsp_autorepeat_in;

   logic             req_xfer;
   logic             exec_go;
   logic             out_hold;

   logic             ev_we;
   logic [EV_W-1:0]  ev_wr_data;
   logic [PTR_W-1:0] ev_wr_addr;
   logic             ch_we;
   logic [PTR_W-1:0] ch_wr_addr;
   logic             map_we;
   logic             map_wr_data;
   logic             map_clear;

   logic             ev_full;
   logic             ch_full;
   logic [SUM_W-1:0] ev_sum;
   logic [SUM_W-1:0] ev_wrap;
   logic [SUM_W-1:0] ch_sum;
   logic [SUM_W-1:0] ch_wrap;
   logic [PTR_W-1:0] ev_head_inc;
   logic [PTR_W-1:0] ch_head_inc;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!out_hold) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      out_hold  = rsp_valid_ff && rsp_stall;
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: exec_go   = !out_hold;
         default: req_stall = 1'b1;
      endcase
   end

   assign req_xfer = req_valid && !req_stall;

   // queue address arithmetic
   always_comb begin
      ev_full     = (event_count_ff == CNT_W'(QUEUE_DEPTH));
      ch_full     = (char_count_ff == CNT_W'(QUEUE_DEPTH));
      ev_sum      = SUM_W'(event_head_ff) + SUM_W'(event_count_ff);
      ch_sum      = SUM_W'(char_head_ff) + SUM_W'(char_count_ff);
      ev_wrap     = (ev_sum >= SUM_W'(QUEUE_DEPTH)) ? ev_sum - SUM_W'(QUEUE_DEPTH) : ev_sum;
      ch_wrap     = (ch_sum >= SUM_W'(QUEUE_DEPTH)) ? ch_sum - SUM_W'(QUEUE_DEPTH) : ch_sum;
      // a full queue overwrites the slot of its oldest entry
      ev_wr_addr  = ev_full ? event_head_ff : ev_wrap[PTR_W-1:0];
      ch_wr_addr  = ch_full ? char_head_ff : ch_wrap[PTR_W-1:0];
      ev_head_inc = (event_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : event_head_ff + 1'b1;
      ch_head_inc = (char_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : char_head_ff + 1'b1;
   end

   // request execution on the registered read data
   always_comb begin
      event_head_in = event_head_ff;
      event_count_in = event_count_ff;
      char_head_in = char_head_ff;
      char_count_in = char_count_ff;
      ev_we = 1'b0;
      ev_wr_data = {(req_type_ff == REQ_PRESS), key_ff};
      ch_we = 1'b0;
      map_we = 1'b0;
      map_wr_data = (req_type_ff == REQ_PRESS);
      map_clear = 1'b0;
      rsp_event_valid_in = 1'b0;
      rsp_event_is_press_in = 1'b0;
      rsp_event_key_in = '0;
      rsp_char_out_in = '0;
      rsp_key_down_in = 1'b0;

      if (exec_go) begin
         unique case (req_type_ff) inside
            REQ_PRESS, REQ_RELEASE: begin
               map_we = 1'b1;
               ev_we  = 1'b1;
               if (ev_full) event_head_in = ev_head_inc;
               else event_count_in = event_count_ff + 1'b1;
            end
            REQ_CHAR_PUSH: begin
               ch_we = 1'b1;
               if (ch_full) char_head_in = ch_head_inc;
               else char_count_in = char_count_ff + 1'b1;
            end
            REQ_READ_KEY: begin
               if (event_count_ff != '0) begin
                  rsp_event_valid_in    = 1'b1;
                  rsp_event_is_press_in = ev_rd_ff[EV_W-1];
                  rsp_event_key_in      = ev_rd_ff[KEY_W-1:0];
                  event_head_in         = ev_head_inc;
                  event_count_in        = event_count_ff - 1'b1;
               end
            end
            REQ_READ_CHAR: begin
               if (char_count_ff != '0) begin
                  rsp_char_out_in = ch_rd_ff;
                  char_head_in    = ch_head_inc;
                  char_count_in   = char_count_ff - 1'b1;
               end
            end
            REQ_QUERY_KEY: begin
               rsp_key_down_in = map_vld_rd_ff && map_rd_ff;
            end
            REQ_FLUSH_KEYS: begin
               event_head_in  = '0;
               event_count_in = '0;
            end
            REQ_FLUSH_CHARS: begin
               char_head_in  = '0;
               char_count_in = '0;
            end
            REQ_FLUSH_BOTH: begin
               event_head_in  = '0;
               event_count_in = '0;
               char_head_in   = '0;
               char_count_in  = '0;
            end
            REQ_CLEAR_MAP: begin
               map_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end

      rsp_key_empty_in  = (event_count_in == '0);
      rsp_char_empty_in = (char_count_in == '0);
      rsp_autorepeat_in = autorepeat_ff;
      rsp_valid_in      = exec_go || out_hold;
      autorepeat_in     = csr_wr_en ? csr_wr_data : autorepeat_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         event_head_ff  <= '0;
         event_count_ff <= '0;
         char_head_ff   <= '0;
         char_count_ff  <= '0;
         autorepeat_ff  <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         map_valid_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         event_head_ff  <= event_head_in;
         event_count_ff <= event_count_in;
         char_head_ff   <= char_head_in;
         char_count_ff  <= char_count_in;
         autorepeat_ff  <= autorepeat_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (map_clear) map_valid_ff <= '0;
         else if (map_we) map_valid_ff[key_ff[MAP_W-1:0]] <= 1'b1;
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_type_ff <= req_type;
         key_ff      <= req_key_code;
         char_ff     <= req_char_code;
      end
      if (exec_go) begin
         rsp_event_valid_ff    <= rsp_event_valid_in;
         rsp_event_is_press_ff <= rsp_event_is_press_in;
         rsp_event_key_ff      <= rsp_event_key_in;
         rsp_char_out_ff       <= rsp_char_out_in;
         rsp_key_down_ff       <= rsp_key_down_in;
         rsp_key_empty_ff      <= rsp_key_empty_in;
         rsp_char_empty_ff     <= rsp_char_empty_in;
         rsp_autorepeat_ff     <= rsp_autorepeat_in;
      end
   end

   // memories: reads issued on the transfer, writes back in the execute cycle
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ev_rd_ff      <= event_mem[event_head_ff];
         ch_rd_ff      <= char_mem[char_head_ff];
         map_rd_ff     <= map_mem[req_key_code[MAP_W-1:0]];
         map_vld_rd_ff <= map_valid_ff[req_key_code[MAP_W-1:0]];
      end
      if (ev_we) event_mem[ev_wr_addr] <= ev_wr_data;
      if (ch_we) char_mem[ch_wr_addr] <= char_ff;
      if (map_we) map_mem[key_ff[MAP_W-1:0]] <= map_wr_data;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_valid      = rsp_event_valid_ff;
   assign rsp_event_is_press   = rsp_event_is_press_ff;
   assign rsp_event_key        = rsp_event_key_ff;
   assign rsp_char_out         = rsp_char_out_ff;
   assign rsp_key_down         = rsp_key_down_ff;
   assign rsp_key_queue_empty  = rsp_key_empty_ff;
   assign rsp_char_queue_empty = rsp_char_empty_ff;
   assign rsp_autorepeat_on    = rsp_autorepeat_ff;

   `KEF_ASSERT_SAME(a_counts_bounded, clock, reset, 1'b1,
      (event_count_ff <= CNT_W'(QUEUE_DEPTH)) && (char_count_ff <= CNT_W'(QUEUE_DEPTH)))
   `KEF_ASSERT_NEXT(a_xfer_to_exec, clock, reset, req_xfer, state_ff == ST_EXEC)
   `KEF_ASSERT_SAME(a_one_field_live, clock, reset, rsp_valid_ff && rsp_event_valid_ff,
      (rsp_char_out_ff == '0) && !rsp_key_down_ff)
   `KEF_ASSERT_NEXT(a_map_cleared, clock, reset,
      exec_go && (req_type_ff == REQ_CLEAR_MAP), map_valid_ff == '0)

endmodule

`default_nettype wire

>>> tb/kef_checker.sv
`timescale 1ns / 1ps

module kef_checker
   import kef_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [KEY_W-1:0]  req_key_code,
   input  wire logic [KEY_W-1:0]  req_char_code,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_event_valid,
   input  wire logic              rsp_event_is_press,
   input  wire logic [KEY_W-1:0]  rsp_event_key,
   input  wire logic [KEY_W-1:0]  rsp_char_out,
   input  wire logic              rsp_key_down,
   input  wire logic              rsp_key_queue_empty,
   input  wire logic              rsp_char_queue_empty,
   input  wire logic              rsp_autorepeat_on,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   output int                     failures,
   output int                     pending
);

   typedef struct packed {
      logic             event_valid;
      logic             event_is_press;
      logic [KEY_W-1:0] event_key;
      logic [KEY_W-1:0] char_out;
      logic             key_down;
      logic             key_queue_empty;
      logic             char_queue_empty;
      logic             autorepeat_on;
   } kbd_status_type;

   logic [255:0]     key_pressed;
   logic [KEY_W:0]   event_ring [QUEUE_DEPTH];
   logic [KEY_W-1:0] char_ring [QUEUE_DEPTH];
   int unsigned      ev_head, ev_count, ch_head, ch_count;
   logic             autorepeat;
   kbd_status_type   status_due [$];
   kbd_status_type   want;
   int               mismatches = 0;
   int               due_count = 0;

   assign failures = mismatches;
   assign pending  = due_count;

   // full ring drops its oldest entry to make room
   function automatic void push_event(input logic [KEY_W:0] ev);
      if (ev_count >= QUEUE_DEPTH) begin
         ev_head = (ev_head + 1) % QUEUE_DEPTH;
         ev_count = QUEUE_DEPTH - 1;
      end
      event_ring[(ev_head + ev_count) % QUEUE_DEPTH] = ev;
      ev_count++;
   endfunction

   function automatic void push_char(input logic [KEY_W-1:0] c);
      if (ch_count >= QUEUE_DEPTH) begin
         ch_head = (ch_head + 1) % QUEUE_DEPTH;
         ch_count = QUEUE_DEPTH - 1;
      end
      char_ring[(ch_head + ch_count) % QUEUE_DEPTH] = c;
      ch_count++;
   endfunction

   function automatic kbd_status_type step_keyboard(input logic [REQ_W-1:0] kind,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [KEY_W-1:0] ch);
      kbd_status_type s;
      logic [KEY_W:0] ev;
      s = '0;
      case (kind)
         REQ_PRESS: begin
            key_pressed[key] = 1'b1;
            push_event({1'b1, key});
         end
         REQ_RELEASE: begin
            key_pressed[key] = 1'b0;
            push_event({1'b0, key});
         end
         REQ_CHAR_PUSH: push_char(ch);
         REQ_READ_KEY: begin
            if (ev_count > 0) begin
               ev = event_ring[ev_head];
               s.event_valid = 1'b1;
               s.event_is_press = ev[KEY_W];
               s.event_key = ev[KEY_W-1:0];
               ev_head = (ev_head + 1) % QUEUE_DEPTH;
               ev_count--;
            end
         end
         REQ_READ_CHAR: begin
            if (ch_count > 0) begin
               s.char_out = char_ring[ch_head];
               ch_head = (ch_head + 1) % QUEUE_DEPTH;
               ch_count--;
            end
         end
         REQ_QUERY_KEY: s.key_down = key_pressed[key];
         REQ_FLUSH_KEYS: begin
            ev_head = 0;
            ev_count = 0;
         end
         REQ_FLUSH_CHARS: begin
            ch_head = 0;
            ch_count = 0;
         end
         REQ_FLUSH_BOTH: begin
            ev_head = 0;
            ev_count = 0;
            ch_head = 0;
            ch_count = 0;
         end
         REQ_CLEAR_MAP: key_pressed = '0;
         default: ;
      endcase
      s.key_queue_empty = (ev_count == 0);
      s.char_queue_empty = (ch_count == 0);
      s.autorepeat_on = autorepeat;
      return s;
   endfunction

   function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_val,
                                       input logic [KEY_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_pressed = '0;
         ev_head = 0;
         ev_count = 0;
         ch_head = 0;
         ch_count = 0;
         autorepeat = 1'b1;
         status_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, got one", $time);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("event_valid", want.event_valid, rsp_event_valid);
               check_field("event_is_press", want.event_is_press, rsp_event_is_press);
               check_field("event_key", want.event_key, rsp_event_key);
               check_field("char_out", want.char_out, rsp_char_out);
               check_field("key_down", want.key_down, rsp_key_down);
               check_field("key_queue_empty", want.key_queue_empty, rsp_key_queue_empty);
               check_field("char_queue_empty", want.char_queue_empty, rsp_char_queue_empty);
               check_field("autorepeat_on", want.autorepeat_on, rsp_autorepeat_on);
            end
         end
         if (csr_wr_en)
            autorepeat = csr_wr_data;
         if (req_valid && !req_stall)
            status_due.push_back(step_keyboard(req_type, req_key_code, req_char_code));
      end
      due_count <= status_due.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench
   import kef_pkg::*;
();

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd10;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [REQ_W-1:0] req_type = '0;
   logic [KEY_W-1:0] req_key_code = '0;
   logic [KEY_W-1:0] req_char_code = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_event_valid;
   logic             rsp_event_is_press;
   logic [KEY_W-1:0] rsp_event_key;
   logic [KEY_W-1:0] rsp_char_out;
   logic             rsp_key_down;
   logic             rsp_key_queue_empty;
   logic             rsp_char_queue_empty;
   logic             rsp_autorepeat_on;
   logic             csr_wr_en = 1'b0;
   logic             csr_wr_data = 1'b0;

   int failures;
   int pending;
   int gap_pct = 30;
   int stall_pct = 30;
   bit hold_rsp = 1'b0;
   int idle_cycles = 0;

   keyboard_event_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_COUNT   (256)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key_code         (req_key_code),
      .req_char_code        (req_char_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_valid      (rsp_event_valid),
      .rsp_event_is_press   (rsp_event_is_press),
      .rsp_event_key        (rsp_event_key),
      .rsp_char_out         (rsp_char_out),
      .rsp_key_down         (rsp_key_down),
      .rsp_key_queue_empty  (rsp_key_queue_empty),
      .rsp_char_queue_empty (rsp_char_queue_empty),
      .rsp_autorepeat_on    (rsp_autorepeat_on),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   kef_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) checker_inst (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key_code         (req_key_code),
      .req_char_code        (req_char_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_valid      (rsp_event_valid),
      .rsp_event_is_press   (rsp_event_is_press),
      .rsp_event_key        (rsp_event_key),
      .rsp_char_out         (rsp_char_out),
      .rsp_key_down         (rsp_key_down),
      .rsp_key_queue_empty  (rsp_key_queue_empty),
      .rsp_char_queue_empty (rsp_char_queue_empty),
      .rsp_autorepeat_on    (rsp_autorepeat_on),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .failures             (failures),
      .pending              (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int len;
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            repeat (len) begin
               @(posedge clock);
               if (hold_rsp)
                  break;
            end
         end
      end
   end

   task automatic offer(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                        input logic [KEY_W-1:0] ch);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_key_code <= key;
      req_char_code <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // one edge first so the last transfer shows up in the pending count
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_autorepeat(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // half the keys come from a small set so presses, releases and queries collide
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 1) == 0)
         return KEY_W'($urandom_range(0, 7));
      return KEY_W'($urandom());
   endfunction

   task automatic random_traffic(input int count);
      int done;
      int len;
      logic [REQ_W-1:0] kind;
      done = 0;
      while (done < count) begin
         case ($urandom_range(0, 9)) inside
            [0:3]: begin
               // push bursts long enough to overrun a full queue
               len = $urandom_range(1, 24);
               repeat (len) begin
                  case ($urandom_range(0, 2))
                     0: kind = REQ_PRESS;
                     1: kind = REQ_RELEASE;
                     default: kind = REQ_CHAR_PUSH;
                  endcase
                  offer(kind, pick_key(), KEY_W'($urandom()));
               end
            end
            [4:6]: begin
               len = $urandom_range(1, 20);
               repeat (len) begin
                  kind = $urandom_range(0, 1) ? REQ_READ_KEY : REQ_READ_CHAR;
                  offer(kind, KEY_W'($urandom()), KEY_W'($urandom()));
               end
            end
            7: begin
               len = $urandom_range(1, 6);
               repeat (len) offer(REQ_QUERY_KEY, pick_key(), KEY_W'($urandom()));
            end
            8: begin
               len = 1;
               case ($urandom_range(0, 3))
                  0: kind = REQ_FLUSH_KEYS;
                  1: kind = REQ_FLUSH_CHARS;
                  2: kind = REQ_FLUSH_BOTH;
                  default: kind = REQ_CLEAR_MAP;
               endcase
               offer(kind, KEY_W'($urandom()), KEY_W'($urandom()));
            end
            default: begin
               len = 1;
               kind = REQ_UNUSED_LO + REQ_W'($urandom_range(0, REQ_UNUSED_HI - REQ_UNUSED_LO));
               offer(kind, KEY_W'($urandom()), KEY_W'($urandom()));
            end
         endcase
         done += len;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset autorepeat value, empty reads, key extremes, flushes
      offer(REQ_READ_KEY, 8'h00, 8'h00);
      offer(REQ_READ_CHAR, 8'h00, 8'h00);
      offer(REQ_QUERY_KEY, 8'hFF, 8'h00);
      offer(REQ_PRESS, 8'hFF, 8'hFF);
      offer(REQ_PRESS, 8'h00, 8'hAA);
      offer(REQ_QUERY_KEY, 8'hFF, 8'h00);
      offer(REQ_RELEASE, 8'h00, 8'h00);
      offer(REQ_QUERY_KEY, 8'h00, 8'h00);
      repeat (3) offer(REQ_READ_KEY, 8'h00, 8'h00);
      offer(REQ_CHAR_PUSH, 8'h55, 8'hFF);
      offer(REQ_CHAR_PUSH, 8'h00, 8'h00);
      repeat (2) offer(REQ_READ_CHAR, 8'h00, 8'h00);
      offer(REQ_CLEAR_MAP, 8'h00, 8'h00);
      offer(REQ_QUERY_KEY, 8'hFF, 8'h00);
      offer(REQ_PRESS, 8'h5A, 8'h00);
      offer(REQ_CHAR_PUSH, 8'h00, 8'h7E);
      offer(REQ_FLUSH_KEYS, 8'h00, 8'h00);
      offer(REQ_FLUSH_CHARS, 8'h00, 8'h00);
      offer(REQ_PRESS, 8'hA5, 8'h00);
      offer(REQ_CHAR_PUSH, 8'h00, 8'h81);
      offer(REQ_FLUSH_BOTH, 8'h00, 8'h00);
      offer(REQ_UNUSED_LO, 8'h00, 8'h00);
      offer(REQ_UNUSED_HI, 8'hFF, 8'hFF);

      wait_drained();
      write_autorepeat(1'b0);
      random_traffic(130);

      wait_drained();
      write_autorepeat(1'b1);
      gap_pct = 0;
      stall_pct = 0;
      random_traffic(60);

      // long hold-off on the result side while requests keep coming
      stall_pct = 20;
      hold_rsp = 1'b1;
      random_traffic(60);
      gap_pct = 30;
      stall_pct = 30;
      random_traffic(60);

      wait_drained();
      write_autorepeat(1'b0);
      gap_pct = 10;
      stall_pct = 50;
      random_traffic(130);

      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
